>>> hdl/mrjc_pkg.sv
// Shared types and constants of the mixed-radix joint counter.
package mrjc_pkg;

  // Value fields carried by one sample beat, and the hardware limit on used variables.
  localparam int NUM_VALUES = 4;
  localparam int MAX_VARS   = 4;
  localparam int VAR_LIMIT  = (MAX_VARS < NUM_VALUES) ? MAX_VARS : NUM_VALUES;
  localparam int VIDX_W     = $clog2(NUM_VALUES);

  localparam int VALUE_W  = 4;
  localparam int RADIX_W  = 5;
  localparam int NVARS_W  = 3;
  localparam int RIDX_W   = 8;
  localparam int CADDR_W  = 8;
  localparam int CCOUNT_W = 16;

  // Configuration port.
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int REGNO_W = 3;

  localparam logic [REGNO_W-1:0] REG_NUM_VARS = 3'd0;
  localparam logic [REGNO_W-1:0] REG_RADIX_0  = 3'd1;
  localparam logic [REGNO_W-1:0] REG_RADIX_1  = 3'd2;
  localparam logic [REGNO_W-1:0] REG_RADIX_2  = 3'd3;
  localparam logic [REGNO_W-1:0] REG_RADIX_3  = 3'd4;

  typedef enum logic [1:0] {
    ACT_COUNT = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_DOMAIN = 2'd1,
    STAT_DEPTH  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_STEP,
    S_CHK,
    S_MEM,
    S_RES
  } state_t;

endpackage

>>> hdl/mixed_radix_joint_counter.sv
// Top level of the mixed-radix joint counter: a contingency table of saturating counts.
//
// Usage. Each input beat carries an action in in_tuser and the operands in in_tdata.
// A count action folds the used variable values into one mixed-radix cell address
// (value_0 most significant, the configured radices as weights) and increments that
// cell. A read action returns one cell by index, and a clear action zeroes the table.
// Every input beat produces exactly one output beat carrying the cell address, the
// count after the action and a status code in out_tuser.
// Timing. The block works on one beat at a time. A count folds the used variables
// one per cycle in the shared multiply-add unit, then issues the table read, does
// the read-modify-write and loads the output register; only then is a new beat
// accepted. A rejected sample skips the memory step. A read issues the table read,
// takes the data and loads the output register, a clear sweeps the table first and
// an unused action code goes straight to the output register. The single table
// memory and the one-variable-per-cycle address fold set this pace.
// Reset. After rst_n the block sweeps the table to zero, one entry per cycle, with
// in_tready low; configuration writes are taken throughout.
// Stalls. Results sit in an output register, so the next beat is accepted while a
// result waits; a new result waits in its last state until out_tready frees the slot.
module mixed_radix_joint_counter
  import mrjc_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // Sample channel.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // value_0[3:0], value_1[7:4], value_2[11:8],
                                        // value_3[15:12], read_index[23:16]
  input  logic [1:0]        in_tuser,   // action[1:0]
  // Result channel.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // cell_address[7:0], cell_count[23:8]
  output logic [1:0]        out_tuser,  // status[1:0]
  // Configuration port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  // The running product saturates at TABLE_DEPTH + 1 once it overflows.
  localparam int PW = $clog2(TABLE_DEPTH + 2);
  localparam int MW = PW + RADIX_W;

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [NVARS_W-1:0]                   num_vars_r;
  logic [NUM_VALUES-1:0][RADIX_W-1:0]   radix_r;
  logic                                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= NVARS_W'(1);
      for (int i = 0; i < NUM_VALUES; i++) begin
        radix_r[i] <= RADIX_W'(2);
      end
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_NUM_VARS: num_vars_r <= cfg_pwdata[NVARS_W-1:0];
        REG_RADIX_0:  radix_r[0] <= cfg_pwdata[RADIX_W-1:0];
        REG_RADIX_1:  radix_r[1] <= cfg_pwdata[RADIX_W-1:0];
        REG_RADIX_2:  radix_r[2] <= cfg_pwdata[RADIX_W-1:0];
        REG_RADIX_3:  radix_r[3] <= cfg_pwdata[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[4:2])
      REG_NUM_VARS: cfg_prdata = CFG_DW'(num_vars_r);
      REG_RADIX_0:  cfg_prdata = CFG_DW'(radix_r[0]);
      REG_RADIX_1:  cfg_prdata = CFG_DW'(radix_r[1]);
      REG_RADIX_2:  cfg_prdata = CFG_DW'(radix_r[2]);
      REG_RADIX_3:  cfg_prdata = CFG_DW'(radix_r[3]);
      default:      cfg_prdata = '0;
    endcase
  end

  // Index of the last used variable. A zero count acts as one, and a count above
  // the hardware limit is clamped to it.
  logic [NVARS_W-1:0] nvars_eff;
  logic [VIDX_W-1:0]  last_idx;

  always_comb begin
    nvars_eff = (num_vars_r == '0) ? NVARS_W'(1) : num_vars_r;
    if (nvars_eff > NVARS_W'(VAR_LIMIT)) begin
      nvars_eff = NVARS_W'(VAR_LIMIT);
    end
    last_idx = VIDX_W'(nvars_eff - NVARS_W'(1));
  end

  // ------------------------------------------------------------------
  // Registers.
  // ------------------------------------------------------------------
  state_t                             state_r, state_nxt;
  logic [AW-1:0]                      clr_ptr_r, clr_ptr_nxt;
  logic                               sweep_cmd_r, sweep_cmd_nxt;
  logic                               out_valid_r, out_valid_nxt;

  action_t                            act_r, act_nxt;
  logic [NUM_VALUES-1:0][VALUE_W-1:0] val_r, val_nxt;
  logic [RIDX_W-1:0]                  ridx_r, ridx_nxt;
  logic [VIDX_W-1:0]                  step_r, step_nxt;
  logic [AW-1:0]                      acc_r, acc_nxt;
  logic [PW-1:0]                      prod_r, prod_nxt;
  logic                               bad_r, bad_nxt;
  logic                               ovf_r, ovf_nxt;
  logic [CADDR_W-1:0]                 res_addr_r, res_addr_nxt;
  logic [CCOUNT_W-1:0]                res_cnt_r, res_cnt_nxt;
  status_t                            res_stat_r, res_stat_nxt;
  logic [CADDR_W-1:0]                 out_addr_r, out_addr_nxt;
  logic [CCOUNT_W-1:0]                out_cnt_r, out_cnt_nxt;
  status_t                            out_stat_r, out_stat_nxt;

  // Table memory.
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  mrjc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // Shared multiply-add unit: one Horner step of the address fold per cycle.
  // ------------------------------------------------------------------
  logic [VALUE_W-1:0] cur_val;
  logic [RADIX_W-1:0] cur_radix;
  logic [MW-1:0]      prod_mul, acc_mul;
  logic               prod_big;
  logic               in_beat, out_free, ridx_ok, last_step;
  logic [COUNT_WIDTH-1:0] cnt_inc;

  assign cur_val   = val_r[step_r];
  assign cur_radix = radix_r[step_r];
  assign prod_mul  = MW'(prod_r) * MW'(cur_radix);
  assign acc_mul   = MW'(acc_r) * MW'(cur_radix) + MW'(cur_val);
  assign prod_big  = prod_mul > MW'(TABLE_DEPTH);

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign ridx_ok   = int'(ridx_r) < TABLE_DEPTH;
  assign last_step = (step_r == last_idx);

  // Counts saturate at the largest value the cell holds.
  assign cnt_inc = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata
                                                      : ram_rdata + COUNT_WIDTH'(1);

  // ------------------------------------------------------------------
  // Next state.
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_ptr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = sweep_cmd_r ? S_RES : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          case (in_tuser)
            ACT_COUNT: state_nxt = S_STEP;
            ACT_READ:  state_nxt = S_CHK;
            ACT_CLEAR: state_nxt = S_CLR;
            default:   state_nxt = S_RES;
          endcase
        end
      end
      S_STEP: begin
        if (last_step) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (act_r == ACT_READ) begin
          state_nxt = ridx_ok ? S_MEM : S_RES;
        end else begin
          state_nxt = (bad_r || ovf_r) ? S_RES : S_MEM;
        end
      end
      S_MEM: state_nxt = S_RES;
      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // ------------------------------------------------------------------
  // Datapath and memory control.
  // ------------------------------------------------------------------
  always_comb begin
    clr_ptr_nxt   = clr_ptr_r;
    sweep_cmd_nxt = sweep_cmd_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    act_nxt       = act_r;
    val_nxt       = val_r;
    ridx_nxt      = ridx_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    bad_nxt       = bad_r;
    ovf_nxt       = ovf_r;
    res_addr_nxt  = res_addr_r;
    res_cnt_nxt   = res_cnt_r;
    res_stat_nxt  = res_stat_r;
    out_addr_nxt  = out_addr_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_ptr_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = acc_r;

    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        if (clr_ptr_r == AW'(TABLE_DEPTH - 1)) begin
          clr_ptr_nxt   = '0;
          sweep_cmd_nxt = 1'b0;
        end else begin
          clr_ptr_nxt = clr_ptr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_beat) begin
          act_nxt       = action_t'(in_tuser);
          val_nxt       = in_tdata[NUM_VALUES*VALUE_W-1:0];
          ridx_nxt      = in_tdata[23:16];
          step_nxt      = '0;
          acc_nxt       = '0;
          prod_nxt      = PW'(1);
          bad_nxt       = 1'b0;
          ovf_nxt       = 1'b0;
          res_addr_nxt  = '0;
          res_cnt_nxt   = '0;
          res_stat_nxt  = STAT_OK;
          sweep_cmd_nxt = (in_tuser == ACT_CLEAR);
        end
      end
      S_STEP: begin
        // An overflowed product is held just above the depth so it stays narrow.
        bad_nxt  = bad_r | (RADIX_W'(cur_val) >= cur_radix);
        ovf_nxt  = ovf_r | prod_big;
        prod_nxt = prod_big ? PW'(TABLE_DEPTH + 1) : PW'(prod_mul);
        acc_nxt  = AW'(acc_mul);
        step_nxt = step_r + VIDX_W'(1);
      end
      S_CHK: begin
        if (act_r == ACT_READ) begin
          res_addr_nxt = ridx_r;
          ram_raddr    = AW'(ridx_r);
          if (ridx_ok) begin
            ram_re = 1'b1;
          end else begin
            res_stat_nxt = STAT_DEPTH;
          end
        end else if (bad_r) begin
          res_stat_nxt = STAT_DOMAIN;
        end else if (ovf_r) begin
          res_stat_nxt = STAT_DEPTH;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_MEM: begin
        if (act_r == ACT_READ) begin
          res_cnt_nxt = CCOUNT_W'(ram_rdata);
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = acc_r;
          ram_wdata    = cnt_inc;
          res_addr_nxt = CADDR_W'(acc_r);
          res_cnt_nxt  = CCOUNT_W'(cnt_inc);
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_cnt_nxt   = res_cnt_r;
          out_stat_nxt  = res_stat_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_ptr_r   <= '0;
      sweep_cmd_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      sweep_cmd_r <= sweep_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    val_r      <= val_nxt;
    ridx_r     <= ridx_nxt;
    step_r     <= step_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    bad_r      <= bad_nxt;
    ovf_r      <= ovf_nxt;
    res_addr_r <= res_addr_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_addr_r};
  assign out_tuser  = out_stat_r;

endmodule

>>> hdl/mrjc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mrjc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/mrjc_checker.sv
// Port-level assertions for the mixed-radix joint counter, bound to the top level.
module mrjc_checker
  import mrjc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat must hold its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // The block works on one sample at a time, so an accepted beat closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // A sample outside its domain is not counted and reports an all-zero payload.
  a_domain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_DOMAIN |-> out_tdata == 24'd0)
    else $error("domain error result carries data");

  // A depth error never reports a count.
  a_depth_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_DEPTH |-> out_tdata[23:8] == 16'd0)
    else $error("depth error result carries a count");

endmodule

bind mixed_radix_joint_counter mrjc_checker u_mrjc_checker (.*);

>>> sim/mrjc_tally_pkg.sv
`timescale 1ns / 1ps
// Beat types and the count-table scoreboard used by the joint counter testbench.
package mrjc_tally_pkg;
  import mrjc_pkg::*;

  localparam int DEPTH = 256;
  localparam logic [CCOUNT_W-1:0] COUNT_CEIL = '1;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One sample beat as it travels on in_tdata and in_tuser.
  typedef struct packed {
    logic [RIDX_W-1:0]                  read_index;
    logic [NUM_VALUES-1:0][VALUE_W-1:0] value;
    logic [1:0]                         action;
  } sample_t;

  typedef struct packed {
    status_t             status;
    logic [CCOUNT_W-1:0] count;
    logic [CADDR_W-1:0]  addr;
  } cell_result_t;

  class tally_book;
    logic [CCOUNT_W-1:0] cells [DEPTH];
    logic [NVARS_W-1:0]  nvars;
    logic [RADIX_W-1:0]  radix [NUM_VALUES];
    cell_result_t        awaited [$];
    int                  mismatches;
    int                  checked;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (radix[i]) radix[i] = RADIX_W'(2);
      nvars      = NVARS_W'(1);
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [REGNO_W-1:0] reg_no, logic [CFG_DW-1:0] value);
      case (reg_no)
        REG_NUM_VARS: nvars    = value[NVARS_W-1:0];
        REG_RADIX_0:  radix[0] = value[RADIX_W-1:0];
        REG_RADIX_1:  radix[1] = value[RADIX_W-1:0];
        REG_RADIX_2:  radix[2] = value[RADIX_W-1:0];
        REG_RADIX_3:  radix[3] = value[RADIX_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted sample and updates the table.
    function void note_sample(sample_t s);
      int           used;
      int           product;
      int           addr;
      bit           bad;
      cell_result_t r;
      r        = '0;
      r.status = STAT_OK;
      case (s.action)
        ACT_COUNT: begin
          used    = (nvars == 0) ? 1 : ((nvars > VAR_LIMIT) ? VAR_LIMIT : int'(nvars));
          product = 1;
          addr    = 0;
          bad     = 1'b0;
          for (int i = 0; i < used; i++) begin
            if (s.value[i] >= radix[i]) bad = 1'b1;
            product = product * radix[i];
            addr    = addr * radix[i] + s.value[i];
          end
          if (bad) begin
            r.status = STAT_DOMAIN;
          end else if (product > DEPTH) begin
            r.status = STAT_DEPTH;
          end else begin
            if (cells[addr] != COUNT_CEIL) cells[addr] = cells[addr] + 1'b1;
            r.addr  = CADDR_W'(addr);
            r.count = cells[addr];
          end
        end
        ACT_READ: begin
          r.addr  = s.read_index;
          r.count = cells[s.read_index];
        end
        ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_result(logic [23:0] tdata, logic [1:0] tuser);
      cell_result_t want;
      if (awaited.size() == 0) begin
        $error("result beat with nothing expected: tdata %h, tuser %h", tdata, tuser);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (tdata[CADDR_W-1:0] !== want.addr) begin
        $error("cell_address: expected %0d, actual %0d", want.addr, tdata[CADDR_W-1:0]);
        mismatches++;
      end
      if (tdata[CADDR_W +: CCOUNT_W] !== want.count) begin
        $error("cell_count: expected %0d, actual %0d", want.count,
               tdata[CADDR_W +: CCOUNT_W]);
        mismatches++;
      end
      if (tuser !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, tuser);
        mismatches++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

>>> sim/mixed_radix_joint_counter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the mixed-radix joint counter.
module mixed_radix_joint_counter_test;
  import mrjc_pkg::*;
  import mrjc_tally_pkg::*;

  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_BEATS   = 235;
  // Length of the back-to-back run on a single cell.
  localparam int FILL_BEATS    = 64;
  localparam int HOLD_CYCLES   = 600;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic [23:0]          in_tdata    = '0;
  logic [1:0]           in_tuser    = '0;
  logic                 out_tready  = 1'b0;
  logic                 cfg_psel    = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr   = '0;
  logic [CFG_DW-1:0]    cfg_pwdata  = '0;
  wire                  in_tready;
  wire                  out_tvalid;
  wire  [23:0]          out_tdata;
  wire  [1:0]           out_tuser;
  wire  [CFG_DW-1:0]    cfg_prdata;
  wire                  cfg_pready;

  tally_book            book;
  // Random idling switches for each side, and a one-shot request for a long
  // receiver hold that the result process counts out on its own.
  bit                   sender_gaps   = 1'b1;
  bit                   receiver_gaps = 1'b1;
  bit                   hold_request  = 1'b0;
  // The testbench's own view of the registers, used only to shape stimulus.
  logic [NVARS_W-1:0]   cur_nvars = NVARS_W'(1);
  logic [RADIX_W-1:0]   cur_radix [NUM_VALUES] = '{default: RADIX_W'(2)};
  int                   settings_used = 0;
  int                   beats_sent    = 0;

  mixed_radix_joint_counter #(
    .TABLE_DEPTH(DEPTH),
    .COUNT_WIDTH(CCOUNT_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Number of value fields that a num_vars setting actually folds into the address.
  function automatic int live_vars(logic [NVARS_W-1:0] nv);
    return (nv == 0) ? 1 : ((nv > VAR_LIMIT) ? VAR_LIMIT : int'(nv));
  endfunction

  function automatic sample_t make_sample(logic [1:0] act, logic [15:0] vals,
                                          logic [RIDX_W-1:0] idx);
    sample_t s;
    s.action     = act;
    s.value      = vals;
    s.read_index = idx;
    return s;
  endfunction

  // Offers one sample beat and returns at the edge where it is taken. The
  // valid stays high afterwards so that back-to-back beats need no gap; the
  // caller lowers it through settle() when a burst ends.
  task automatic send_beat(input sample_t s);
    while (sender_gaps && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.read_index, s.value};
    in_tuser  <= s.action;
    do @(posedge clk); while (!in_tready);
    book.note_sample(s);
    beats_sent++;
  endtask

  // Ends a burst and waits until every expected result beat has come back.
  // Each sample yields exactly one result, so the block is idle after that.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then the bus goes idle so writes never overlap.
  task automatic cfg_write(input logic [REGNO_W-1:0] reg_no, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_no, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    book.set_reg(reg_no, value);
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [NVARS_W-1:0] nv, input logic [RADIX_W-1:0] r0,
                               input logic [RADIX_W-1:0] r1, input logic [RADIX_W-1:0] r2,
                               input logic [RADIX_W-1:0] r3);
    settle();
    cfg_write(REG_NUM_VARS, CFG_DW'(nv));
    cfg_write(REG_RADIX_0, CFG_DW'(r0));
    cfg_write(REG_RADIX_1, CFG_DW'(r1));
    cfg_write(REG_RADIX_2, CFG_DW'(r2));
    cfg_write(REG_RADIX_3, CFG_DW'(r3));
    cur_nvars    = nv;
    cur_radix[0] = r0;
    cur_radix[1] = r1;
    cur_radix[2] = r2;
    cur_radix[3] = r3;
    settings_used++;
  endtask

  // Result side: checks every accepted result beat against the oldest
  // expectation, and drives out_tready with random gaps or a long hold.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_tvalid && out_tready) book.check_result(out_tdata, out_tuser);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= !(receiver_gaps && $urandom_range(99) < 32);
      end
      @(posedge clk);
    end
  end

  // Generous fixed limit, several times the slowest correct run including every
  // clearing sweep and the long receiver hold.
  initial begin : watchdog
    #(10_000_000);
    $error("run did not finish in time, %0d results still expected", book.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    sample_t s;
    int      used;
    int      budget;
    int      live_cells;
    int      pick;
    logic [RADIX_W-1:0] r [NUM_VALUES];
    logic [NVARS_W-1:0] nv;

    book = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The first beats run on the reset values: one variable
    // of radix 2, so only values 0 and 1 are in the domain.
    send_beat(make_sample(ACT_COUNT, 16'h0000, 8'd0));
    send_beat(make_sample(ACT_COUNT, 16'hFFF1, 8'd0));
    send_beat(make_sample(ACT_COUNT, 16'h000F, 8'd0));
    send_beat(make_sample(ACT_READ, 16'h0000, 8'd0));
    send_beat(make_sample(ACT_READ, 16'hFFFF, 8'd255));
    send_beat(make_sample(ACT_UNUSED, 16'hA5C3, 8'h5A));

    // Four variables of radix 4 fill the table exactly: the top cell and a
    // value one past its domain in the least significant variable.
    apply_setting(3'd4, 5'd4, 5'd4, 5'd4, 5'd4);
    send_beat(make_sample(ACT_COUNT, 16'h3333, 8'd0));
    send_beat(make_sample(ACT_COUNT, 16'h0000, 8'd0));
    send_beat(make_sample(ACT_READ, 16'h0000, 8'd255));
    send_beat(make_sample(ACT_COUNT, 16'h4333, 8'd0));

    // The product of the radices exceeds the table, and a domain violation
    // must win over the depth check.
    apply_setting(3'd4, 5'd16, 5'd16, 5'd2, 5'd31);
    send_beat(make_sample(ACT_COUNT, 16'h01FF, 8'd0));
    send_beat(make_sample(ACT_COUNT, 16'h02FF, 8'd0));

    // A num_vars of zero behaves as one; a radix of zero rejects every value.
    apply_setting(3'd0, 5'd0, 5'd16, 5'd16, 5'd16);
    send_beat(make_sample(ACT_COUNT, 16'h0000, 8'd0));
    apply_setting(3'd0, 5'd31, 5'd0, 5'd0, 5'd0);
    send_beat(make_sample(ACT_COUNT, 16'hFFFF, 8'd0));

    // A num_vars above the limit behaves as four; then a clear empties the table.
    apply_setting(3'd7, 5'd1, 5'd1, 5'd16, 5'd16);
    send_beat(make_sample(ACT_COUNT, 16'hFF00, 8'd0));
    send_beat(make_sample(ACT_CLEAR, 16'hFFFF, 8'd255));
    send_beat(make_sample(ACT_READ, 16'h0000, 8'd255));
    send_beat(make_sample(ACT_READ, 16'h0000, 8'd15));
    send_beat(make_sample(ACT_COUNT, 16'hFF00, 8'd0));

    // Back-to-back run on a single cell with no idling on either side. This
    // is also the long stretch without gaps.
    apply_setting(3'd1, 5'd1, 5'd2, 5'd2, 5'd2);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    repeat (FILL_BEATS) send_beat(make_sample(ACT_COUNT, 16'($urandom) & 16'hFFF0,
                                              RIDX_W'($urandom)));
    send_beat(make_sample(ACT_READ, 16'($urandom), 8'd0));
    settle();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;

    // Random phases, each under its own register setting. The first three
    // pin the extremes; the rest mostly keep the table within its depth so
    // that counts land, with a share of arbitrary settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          nv = 3'd2;
          r  = '{5'd16, 5'd16, 5'($urandom), 5'($urandom)};
        end
        1: begin
          nv = 3'd4;
          r  = '{5'd1, 5'd1, 5'd1, 5'd1};
        end
        2: begin
          nv = 3'd0;
          r  = '{5'd31, 5'($urandom), 5'($urandom), 5'($urandom)};
        end
        default: begin
          nv     = ($urandom_range(99) < 70) ? NVARS_W'($urandom_range(4, 1))
                                             : NVARS_W'($urandom);
          used   = live_vars(nv);
          budget = DEPTH;
          for (int i = 0; i < NUM_VALUES; i++) begin
            if (i < used && $urandom_range(99) < 80) begin
              r[i]   = RADIX_W'($urandom_range((budget < 16) ? budget : 16, 1));
              budget = budget / r[i];
            end else begin
              r[i] = RADIX_W'($urandom_range(31, 0));
            end
          end
        end
      endcase
      apply_setting(nv, r[0], r[1], r[2], r[3]);

      used       = live_vars(cur_nvars);
      live_cells = 1;
      for (int i = 0; i < used; i++) live_cells = live_cells * cur_radix[i];
      if (live_cells == 0 || live_cells > DEPTH) live_cells = DEPTH;

      // The single-cell phase also holds the receiver off for a long stretch
      // while beats keep coming, so the block backs up and stalls its input.
      if (p == 1) hold_request = 1'b1;

      for (int k = 0; k < PHASE_BEATS; k++) begin
        s.value      = 16'($urandom);
        s.read_index = RIDX_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 72) begin
          s.action = ACT_COUNT;
          if ($urandom_range(99) < 88) begin
            for (int i = 0; i < used; i++) begin
              if (cur_radix[i] != 0)
                s.value[i] = VALUE_W'($urandom_range(
                    ((cur_radix[i] > 16) ? 16 : int'(cur_radix[i])) - 1, 0));
            end
          end
        end else if (pick < 92) begin
          s.action = ACT_READ;
          if ($urandom_range(99) < 75) s.read_index = RIDX_W'($urandom_range(live_cells - 1, 0));
        end else if (pick < 95) begin
          s.action = ACT_CLEAR;
        end else begin
          s.action = ACT_UNUSED;
        end
        send_beat(s);
      end
    end

    // Drain, then leave room for any stray result beat to show up.
    settle();
    repeat (DEPTH + 16) @(posedge clk);

    $display("Drove %0d sample beats (counts, reads, clears, unused codes) over %0d settings,",
             beats_sent, settings_used);
    $display("including a gapless single-cell run and a long receiver hold; %0d results checked.",
             book.checked);
    if (book.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
